[rtl/rrs_pkg.sv]
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the ranked record store
// Operation codes, controller states and the command word driven into the
// row of record cells.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int unsigned SCORE_W     = 9;
  localparam int unsigned NAME_PORT_W = 64;
  localparam int unsigned OP_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_LIST   = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic load;    // insert the broadcast record at its ranked place
    logic rotate;  // move every occupied record one place toward the head, head to the tail
  } cell_cmd_t;

endpackage

[rtl/rrs_cell.sv]
// ----------------------------------------------------------------------------
// rrs_cell: one slot of the ranked record row
// Holds one record, ranks a broadcast record against it, and takes a record
// from its left neighbor, its right neighbor, the head or the broadcast.
// ----------------------------------------------------------------------------
module rrs_cell
  import rrs_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7,
  parameter int unsigned NW  = 64
) (
  input  logic               clk_i,
  input  cell_cmd_t          cmd_i,
  input  logic [CW-1:0]      count_i,
  input  logic [SCORE_W-1:0] new_score_i,
  input  logic [NW-1:0]      new_name_i,
  input  logic [SCORE_W-1:0] left_score_i,
  input  logic [NW-1:0]      left_name_i,
  input  logic               left_before_i,
  input  logic [SCORE_W-1:0] right_score_i,
  input  logic [NW-1:0]      right_name_i,
  input  logic [SCORE_W-1:0] head_score_i,
  input  logic [NW-1:0]      head_name_i,
  output logic [SCORE_W-1:0] score_o,
  output logic [NW-1:0]      name_o,
  output logic               before_o
);

  localparam logic [CW-1:0] IdxC  = CW'(IDX);
  localparam logic [CW-1:0] NextC = CW'(IDX + 1);

  logic [SCORE_W-1:0] score_q, score_d;
  logic [NW-1:0]      name_q, name_d;
  logic               occupied;

  assign occupied = (IdxC < count_i);

  // New record ranks strictly ahead of the one held here
  assign before_o = occupied &&
                    ((new_score_i > score_q) ||
                     ((new_score_i == score_q) && (new_name_i < name_q)));

  always_comb begin
    score_d = score_q;
    name_d  = name_q;
    if (cmd_i.load) begin
      priority if (left_before_i) begin
        score_d = left_score_i;
        name_d  = left_name_i;
      end else if (before_o || (IdxC == count_i)) begin
        score_d = new_score_i;
        name_d  = new_name_i;
      end else begin
        // Hold the record
      end
    end else if (cmd_i.rotate) begin
      priority if (NextC < count_i) begin
        score_d = right_score_i;
        name_d  = right_name_i;
      end else if (NextC == count_i) begin
        score_d = head_score_i;
        name_d  = head_name_i;
      end else begin
        // Hold the record
      end
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    name_q  <= name_d;
  end

  assign score_o = score_q;
  assign name_o  = name_q;

endmodule

[rtl/ranked_record_store_with_search.sv]
// ----------------------------------------------------------------------------
// ranked_record_store_with_search: ranked record store with score search
// Keeps up to CAPACITY records (score, name) ranked by score high to low and
// name ascending, in a row of cells. Loads insert, list and search items
// stream the records out in rank order.
// ----------------------------------------------------------------------------
//
//  port group  dir  tdata (low bit up)                      tuser / tlast
//  s_axis      in   record_score, record_name, query_score  operation, first_record
//  m_axis      out  out_name, out_score                     not_found, overflow / last
//
//  Load: the new record is ranked against every cell at once and the row
//  opens a gap at its place in the same edge.
//  List or search: an accept step, then one rotation per stored record, the
//  head cell feeding the output register. Back pressure freezes the rotation;
//  no word is taken during a scan or while the output register is full and
//  not read. Reset clears control state, record count and output valid only.
// ----------------------------------------------------------------------------
module ranked_record_store_with_search
  import rrs_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [87:0] s_axis_tdata_i,   // record_score[8:0], record_name[72:9],
                                        // query_score[81:73], zero fill
  input  logic [2:0]  s_axis_tuser_i,   // operation[1:0], first_record[2]
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // out_name[63:0], out_score[72:64], zero fill
  output logic [1:0]  m_axis_tuser_o,   // not_found[0], overflow[1]
  output logic        m_axis_tlast_o    // last_result
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = $clog2(CAPACITY);
  localparam int unsigned NW = 8 * NAME_BYTES;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  // Unpack the input word; name bytes above NAME_BYTES are dropped here
  logic [OP_W-1:0]    in_op;
  logic               in_first;
  logic [SCORE_W-1:0] in_score;
  logic [NW-1:0]      in_name;
  logic [SCORE_W-1:0] in_query;

  assign in_op    = s_axis_tuser_i[1:0];
  assign in_first = s_axis_tuser_i[2];
  assign in_score = s_axis_tdata_i[8:0];
  assign in_name  = s_axis_tdata_i[9 +: NW];
  assign in_query = s_axis_tdata_i[81:73];

  // Control state
  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [KW-1:0]      step_q, step_d;
  logic [SCORE_W-1:0] query_q, query_d;
  logic               search_q, search_d;
  logic               found_q, found_d;

  // Output register
  logic                   out_valid_q;
  logic [NAME_PORT_W-1:0] out_name_q, out_name_d;
  logic [SCORE_W-1:0]     out_score_q, out_score_d;
  logic                   out_nf_q, out_nf_d;
  logic                   out_ov_q, out_ov_d;
  logic                   out_last_q, out_last_d;
  logic                   out_load;
  logic                   out_free;

  // Cell row
  cell_cmd_t          cell_cmd;
  logic [CW-1:0]      cell_count;
  logic [SCORE_W-1:0] cell_score  [CAPACITY];
  logic [NW-1:0]      cell_name   [CAPACITY];
  logic               cell_before [CAPACITY];

  logic               in_fire;
  logic [CW-1:0]      load_count;
  logic               last_step;
  logic               head_match;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign load_count = in_first ? '0 : count_q;
  assign last_step  = ((CW'(step_q) + CW'(1)) == count_q);
  assign head_match = (cell_score[0] == query_q);

  // Row of cells: each takes its left neighbor on insert, its right neighbor
  // on rotate; the last occupied cell wraps around to the head.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SCORE_W-1:0] left_score, right_score;
    logic [NW-1:0]      left_name, right_name;
    logic               left_before;

    if (i == 0) begin : g_first
      assign left_score  = '0;
      assign left_name   = '0;
      assign left_before = 1'b0;
    end else begin : g_inner_left
      assign left_score  = cell_score[i-1];
      assign left_name   = cell_name[i-1];
      assign left_before = cell_before[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_score = cell_score[0];
      assign right_name  = cell_name[0];
    end else begin : g_inner_right
      assign right_score = cell_score[i+1];
      assign right_name  = cell_name[i+1];
    end

    rrs_cell #(
      .IDX (i),
      .CW  (CW),
      .NW  (NW)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cell_cmd),
      .count_i       (cell_count),
      .new_score_i   (in_score),
      .new_name_i    (in_name),
      .left_score_i  (left_score),
      .left_name_i   (left_name),
      .left_before_i (left_before),
      .right_score_i (right_score),
      .right_name_i  (right_name),
      .head_score_i  (cell_score[0]),
      .head_name_i   (cell_name[0]),
      .score_o       (cell_score[i]),
      .name_o        (cell_name[i]),
      .before_o      (cell_before[i])
    );
  end

  // Next state, cell commands and output word
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    query_d     = query_q;
    search_d    = search_q;
    found_d     = found_q;
    cell_cmd    = '0;
    cell_count  = count_q;
    out_load    = 1'b0;
    out_name_d  = NAME_PORT_W'(cell_name[0]);
    out_score_d = cell_score[0];
    out_nf_d    = 1'b0;
    out_ov_d    = 1'b0;
    out_last_d  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_LOAD: begin
              // Echo the record; refuse it when the row is full
              out_load    = 1'b1;
              out_name_d  = NAME_PORT_W'(in_name);
              out_score_d = in_score;
              cell_count  = load_count;
              if (load_count == CapC) begin
                out_ov_d = 1'b1;
                count_d  = load_count;
              end else begin
                cell_cmd.load = 1'b1;
                count_d       = load_count + CW'(1);
              end
            end
            OP_LIST: begin
              if (count_q != '0) begin
                state_d  = ST_SCAN;
                step_d   = '0;
                search_d = 1'b0;
                found_d  = 1'b0;
              end
            end
            OP_SEARCH: begin
              query_d = in_query;
              if (count_q == '0) begin
                // Empty store: miss at once
                out_load    = 1'b1;
                out_name_d  = '0;
                out_score_d = in_query;
                out_nf_d    = 1'b1;
              end else begin
                state_d  = ST_SCAN;
                step_d   = '0;
                search_d = 1'b1;
                found_d  = 1'b0;
              end
            end
            default: begin
              // Unused operation: drop the word
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Head cell holds record step_q; cell 1 holds the one after it
        priority if (!search_q) begin
          out_load   = 1'b1;
          out_last_d = last_step;
        end else if (head_match) begin
          out_load   = 1'b1;
          out_last_d = last_step || (cell_score[1] != query_q);
        end else if (last_step && !found_q) begin
          out_load    = 1'b1;
          out_name_d  = '0;
          out_score_d = query_q;
          out_nf_d    = 1'b1;
        end else begin
          // Skip this record: no word
        end

        if (out_load && !out_free) begin
          // Hold the row until the output register frees up
          out_load = 1'b0;
        end else begin
          cell_cmd.rotate = 1'b1;
          step_d          = step_q + KW'(1);
          found_d         = found_q || (search_q && head_match);
          if (last_step) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      search_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      step_q   <= step_d;
      search_q <= search_d;
      found_q  <= found_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    query_q <= query_d;
    if (out_load) begin
      out_name_q  <= out_name_d;
      out_score_q <= out_score_d;
      out_nf_q    <= out_nf_d;
      out_ov_q    <= out_ov_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_score_q, out_name_q};
  assign m_axis_tuser_o  = {out_ov_q, out_nf_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

[verif/ranked_record_store_with_search_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranked_record_store_with_search_tb: self-checking bench of the record store
// Streams loads, lists and searches into the store and keeps its own ranked
// copy of the records. Every result word is checked, field by field, against
// the word that copy says is due next.
// ----------------------------------------------------------------------------
module ranked_record_store_with_search_tb
  import rrs_pkg::*;
();

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned ITEM_TARGET  = 270;   // stop filling the random part here
  localparam int unsigned IDLE_PCT     = 6;     // chance of a bubble per cycle, each side
  localparam int unsigned QUIET_FROM   = 1000;  // cycle window with no bubbles at all
  localparam int unsigned QUIET_TO     = 2500;
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles without any handshake
  localparam int unsigned DRAIN_CYCLES = CAPACITY + 16;

  // Operation code the store must ignore
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic                   first;
    logic [SCORE_W-1:0]     score;
    logic [NAME_PORT_W-1:0] name;
    logic [SCORE_W-1:0]     query;
  } store_item_t;

  typedef struct packed {
    logic [NAME_PORT_W-1:0] name;
    logic [SCORE_W-1:0]     score;
    logic                   not_found;
    logic                   overflow;
    logic                   last;
  } store_word_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the ports of the block
  // --------------------------------------------------------------------------
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [87:0] s_axis_tdata_i  = '0;   // record_score, record_name, query_score, zero fill
  logic [2:0]  s_axis_tuser_i  = '0;   // operation, first_record
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;         // out_name, out_score, zero fill
  logic [1:0]  m_axis_tuser_o;         // not_found, overflow
  logic        m_axis_tlast_o;         // last_result

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  ranked_record_store_with_search #(
    .CAPACITY  (CAPACITY),
    .NAME_BYTES(8)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  store_item_t pending_items[$];     // items not yet offered to the block
  store_word_t due_words[$];         // result words owed by the block, oldest first
  store_item_t item_on_bus;          // item currently offered on the slave side

  // Ranked copy of the store: index 0 is the best record
  logic [SCORE_W-1:0]     ranked_score[CAPACITY];
  logic [NAME_PORT_W-1:0] ranked_name[CAPACITY];
  int unsigned            ranked_count = 0;

  // Per-set pools so that loads collide on score and name
  logic [SCORE_W-1:0]     score_pool[4];
  logic [NAME_PORT_W-1:0] name_pool[4];

  int unsigned stim_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_count   = 0;
  int unsigned n_loads = 0, n_refused = 0, n_lists = 0, n_searches = 0, n_misses = 0;
  int unsigned n_words = 0;

  logic idling_allowed;
  assign idling_allowed = !(cycle_count >= QUIET_FROM && cycle_count < QUIET_TO);

  // --------------------------------------------------------------------------
  // Rank one accepted item into the copy and queue the words it must produce
  // --------------------------------------------------------------------------
  task automatic rank_and_expect(input store_item_t it);
    store_word_t w;
    int unsigned n, pos, i;
    n = ranked_count;
    w = '0;
    case (it.op)
      OP_LOAD: begin
        n_loads++;
        if (it.first) n = 0;      // restart the set before inserting
        w.name  = it.name;
        w.score = it.score;
        w.last  = 1'b1;
        if (n >= CAPACITY) begin
          // full: refuse the record, keep the store as it is
          w.overflow = 1'b1;
          n_refused++;
        end else begin
          // walk past every record that ranks at or before the new one, so
          // an equal record lands behind its twins
          pos = 0;
          while (pos < n && !(it.score > ranked_score[pos] ||
                 (it.score == ranked_score[pos] && it.name < ranked_name[pos])))
            pos++;
          for (i = n; i > pos; i--) begin
            ranked_score[i] = ranked_score[i-1];
            ranked_name[i]  = ranked_name[i-1];
          end
          ranked_score[pos] = it.score;
          ranked_name[pos]  = it.name;
          n++;
        end
        ranked_count = n;
        due_words.push_back(w);
      end
      OP_LIST: begin
        n_lists++;
        // an empty store owes nothing
        for (i = 0; i < n; i++) begin
          w.name  = ranked_name[i];
          w.score = ranked_score[i];
          w.last  = (i + 1 == n);
          due_words.push_back(w);
        end
      end
      OP_SEARCH: begin
        n_searches++;
        // matches sit next to each other since the copy is ranked by score
        pos = 0;
        while (pos < n && ranked_score[pos] > it.query) pos++;
        if (pos == n || ranked_score[pos] != it.query) begin
          n_misses++;
          w.score     = it.query;
          w.not_found = 1'b1;
          w.last      = 1'b1;
          due_words.push_back(w);
        end else begin
          for (i = pos; i < n && ranked_score[i] == it.query; i++) begin
            w.name  = ranked_name[i];
            w.score = ranked_score[i];
            w.last  = !(i + 1 < n && ranked_score[i+1] == it.query);
            due_words.push_back(w);
          end
        end
      end
      default: ;                  // unused code: no words, no change
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers: unused fields of an item carry random noise
  // --------------------------------------------------------------------------
  task automatic queue_load(input logic first, input logic [SCORE_W-1:0] score,
                            input logic [NAME_PORT_W-1:0] name);
    store_item_t it;
    it.op    = OP_LOAD;
    it.first = first;
    it.score = score;
    it.name  = name;
    it.query = SCORE_W'($urandom_range(0, 511));
    pending_items.push_back(it);
    stim_count++;
  endtask

  task automatic queue_query(input logic [OP_W-1:0] op, input logic [SCORE_W-1:0] query);
    store_item_t it;
    it.op    = op;
    it.first = 1'($urandom_range(0, 1));
    it.score = SCORE_W'($urandom_range(0, 511));
    it.name  = {$urandom(), $urandom()};
    it.query = query;
    pending_items.push_back(it);
    if (op != OP_NONE) stim_count++;
  endtask

  function automatic logic [SCORE_W-1:0] pick_score();
    if ($urandom_range(0, 99) < 85) return score_pool[$urandom_range(0, 3)];
    return SCORE_W'($urandom_range(0, 511));
  endfunction

  function automatic logic [NAME_PORT_W-1:0] pick_name();
    if ($urandom_range(0, 99) < 30) return name_pool[$urandom_range(0, 3)];
    return {$urandom(), $urandom()};
  endfunction

  // --------------------------------------------------------------------------
  // Slave-side driver: offer the next pending item, hold it until taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) rank_and_expect(item_on_bus);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_items.size() != 0 &&
            !(idling_allowed && $urandom_range(0, 99) < IDLE_PCT)) begin
          item_on_bus = pending_items.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {6'd0, item_on_bus.query, item_on_bus.name, item_on_bus.score};
          s_axis_tuser_i  <= {item_on_bus.first, item_on_bus.op};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Master-side monitor: take words at random back pressure and check them
  // --------------------------------------------------------------------------
  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    store_word_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_words++;
        if (due_words.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, actual name %h score %0d %b%b%b",
                   $time, m_axis_tdata_o[63:0], m_axis_tdata_o[72:64],
                   m_axis_tuser_o[0], m_axis_tuser_o[1], m_axis_tlast_o);
          fail_count++;
        end else begin
          want = due_words.pop_front();
          check_field("out_name",    want.name,      m_axis_tdata_o[63:0]);
          check_field("out_score",   want.score,     m_axis_tdata_o[72:64]);
          check_field("not_found",   want.not_found, m_axis_tuser_o[0]);
          check_field("overflow",    want.overflow,  m_axis_tuser_o[1]);
          check_field("last_result", want.last,      m_axis_tlast_o);
        end
      end
      m_axis_tready_i <= !(idling_allowed && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither side moves a word for too long
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d words still due",
               $time, STALL_LIMIT, due_words.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned set_no, set_size, j, roll;

    // Directed part: empty store, extremes, ties, twins, ignored codes
    queue_query(OP_LIST, 9'd0);                         // empty list: nothing back
    queue_query(OP_SEARCH, 9'd0);                       // search on an empty store
    queue_query(OP_NONE, 9'd511);                       // unused code
    queue_load(1'b1, 9'd0, 64'd0);
    queue_load(1'b0, 9'd511, '1);                       // score above 399, all-ones name
    queue_load(1'b0, 9'd399, 64'h4142_4300_0000_0000);
    queue_load(1'b0, 9'd399, 64'h4141_0000_0000_0000); // same score, lower name
    queue_load(1'b0, 9'd399, 64'h4141_0000_0000_0000); // twin goes behind
    queue_load(1'b0, 9'd100, 64'h5a00_0000_0000_0000);
    queue_query(OP_LIST, 9'd0);
    queue_query(OP_SEARCH, 9'd399);
    queue_query(OP_SEARCH, 9'd511);
    queue_query(OP_SEARCH, 9'd0);
    queue_query(OP_SEARCH, 9'd200);                     // miss
    queue_query(OP_NONE, 9'd0);
    queue_load(1'b1, 9'd5, 64'h0102_0304_0506_0708);    // restart with one record
    queue_query(OP_LIST, 9'd0);
    queue_query(OP_SEARCH, 9'd5);

    // Random part: sets that start with a restart, loads of colliding records
    // with searches and lists mixed in; one set runs past capacity
    set_no = 0;
    while (stim_count < ITEM_TARGET) begin
      for (j = 0; j < 4; j++) begin
        score_pool[j] = SCORE_W'($urandom_range(0, 511));
        name_pool[j]  = {$urandom(), $urandom()};
      end
      if (set_no == 2)
        set_size = CAPACITY + 4;
      else if ($urandom_range(0, 99) < 80)
        set_size = $urandom_range(1, 10);
      else
        set_size = $urandom_range(11, 30);
      queue_load(1'b1, pick_score(), pick_name());
      for (j = 1; j < set_size; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 12)      queue_query(OP_SEARCH, pick_score());
        else if (roll < 15) queue_query(OP_LIST, SCORE_W'($urandom_range(0, 511)));
        else if (roll < 17) queue_query(OP_NONE, SCORE_W'($urandom_range(0, 511)));
        // now and then break the set with a stray restart
        queue_load(roll >= 97 && set_no != 2, pick_score(), pick_name());
      end
      queue_query(OP_LIST, SCORE_W'($urandom_range(0, 511)));
      queue_query(OP_SEARCH, pick_score());
      queue_query(OP_SEARCH, SCORE_W'($urandom_range(0, 511)));
      set_no++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: everything offered and taken, every owed word back, then linger
    // long enough for a full scan to show any stray word
    @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid_i || due_words.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (due_words.size() != 0) begin
      $display("%0t ns: %0d words never arrived", $time, due_words.size());
      fail_count++;
    end

    $display("Covered %0d loads (%0d refused as full), %0d lists, %0d searches (%0d misses)",
             n_loads, n_refused, n_lists, n_searches, n_misses);
    $display("Checked %0d result words over %0d cycles, %0d mismatches",
             n_words, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
